/* sv/psnc_pkg.sv */
// types and constants shared by the palette store and nearest color search
package psnc_pkg;

  // default palette depth, reserved entry included
  localparam int unsigned PALETTE_SIZE_DEF = 16;

  // channel width and squared rgb distance width (3 * 255^2 fits in 18 bits)
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SQ_W   = 2 * CHAN_W;
  localparam int unsigned DIST_W = SQ_W + 2;

  // operation codes carried in the mode field
  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_CONTAINS = 2'd1;
  localparam logic [1:0] MODE_NEAREST  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic       refused;
    logic       found;
    logic [3:0] nearest_index;
    logic [4:0] entry_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

/* sv/palette_store_nearest_color.sv */
// palette store with exact-match and nearest-color search, top level
//
// usage: items arrive on in_valid/in_ready carrying a mode and an rgba color;
// one result item leaves on out_valid/out_ready for every input item.
// add appends the color at the current count (refused when full), contains
// matches all four channels against entries 0 to count-1, nearest finds the
// entry 1 to count-1 with the smallest squared rgb distance (lowest index on
// ties, 1 when the palette holds only the reserved entry).
// the palette sits in one synchronous ram with a registered read port.
// add, the unused mode and a search with only the reserved entry go from idle
// straight to the done state, which loads the output register once it is free;
// other searches stream one ram read per cycle through a read, a square and a
// sum/compare stage and reach done once the last entry has left the pipeline.
// one item is in work at a time; in_ready is high in idle, also while a
// finished result still waits in the output register.
// reset: count returns to 1, entry 0 reads as all zeros (it is never stored,
// the search treats it as a constant), the output register empties.
// a stalled receiver holds the result in the output register; the next item
// then runs to completion and waits until the register frees up.
module palette_store_nearest_color #(
  parameter int unsigned PALETTE_SIZE = psnc_pkg::PALETTE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  psnc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output psnc_pkg::out_item_t out_item
);

  localparam int unsigned IDX_W  = $clog2(PALETTE_SIZE);
  localparam int unsigned CNT_W  = $clog2(PALETTE_SIZE + 1);
  localparam int unsigned WORD_W = 4 * psnc_pkg::CHAN_W;
  localparam int unsigned CW     = psnc_pkg::CHAN_W;
  localparam int unsigned SQ_W   = psnc_pkg::SQ_W;
  localparam int unsigned DIST_W = psnc_pkg::DIST_W;

  // control state
  psnc_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] issue_idx_r;
  logic             s1_vld_r, s2_vld_r;
  logic             out_valid_r;

  // item and datapath registers
  psnc_pkg::in_item_t  item_r;
  logic [WORD_W-1:0]   rd_data_r;
  logic [IDX_W-1:0]    s1_idx_r, s2_idx_r;
  logic [SQ_W-1:0]     sq_r_r, sq_g_r, sq_b_r;
  logic                s2_match_r;
  logic [DIST_W-1:0]   best_r;
  logic [IDX_W-1:0]    near_r;
  logic                found_r;
  logic                refused_r;
  psnc_pkg::out_item_t out_item_r;

  // palette ram, entry 0 never written
  logic [WORD_W-1:0] entry_mem [PALETTE_SIZE];

  logic              in_acc;
  logic              rd_en;
  logic              wr_en;
  logic              load_out;
  logic              full;
  logic              scan_done;
  logic              wants_scan;
  logic [WORD_W-1:0] in_key;
  logic [WORD_W-1:0] item_key;
  logic [CW-1:0]     d_r, d_g, d_b;
  logic [DIST_W-1:0] dist_sum;

  assign in_acc   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(PALETTE_SIZE));
  assign in_key   = {in_item.red, in_item.green, in_item.blue, in_item.alpha};
  assign item_key = {item_r.red, item_r.green, item_r.blue, item_r.alpha};
  assign wr_en    = in_acc && (in_item.mode == psnc_pkg::MODE_ADD) && !full;

  // search runs only when something lies beyond the reserved entry
  assign wants_scan = ((in_item.mode == psnc_pkg::MODE_CONTAINS) ||
                       (in_item.mode == psnc_pkg::MODE_NEAREST)) &&
                      (count_r > CNT_W'(1));

  // all reads issued and both pipeline stages drained
  assign scan_done = (issue_idx_r == count_r) && !s1_vld_r && !s2_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psnc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = wants_scan ? psnc_pkg::ST_SCAN : psnc_pkg::ST_DONE;
        end
      end
      psnc_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = psnc_pkg::ST_DONE;
        end
      end
      psnc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = psnc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psnc_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      psnc_pkg::ST_IDLE: in_ready = 1'b1;
      psnc_pkg::ST_SCAN: rd_en    = (issue_idx_r < count_r);
      psnc_pkg::ST_DONE: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psnc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ram: one write port for add, one read port for the scan
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[count_r[IDX_W-1:0]] <= in_key;
    end
    if (rd_en) begin
      rd_data_r <= entry_mem[issue_idx_r[IDX_W-1:0]];
    end
  end

  // count and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_W'(1);
      issue_idx_r <= CNT_W'(1);
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (in_acc) begin
        issue_idx_r <= CNT_W'(1);
      end else if (rd_en) begin
        issue_idx_r <= issue_idx_r + CNT_W'(1);
      end
      s1_vld_r <= rd_en;
      s2_vld_r <= s1_vld_r;
    end
  end

  // stage 1: channel differences squared, exact compare
  always_comb begin
    d_r = (item_r.red > rd_data_r[4*CW-1:3*CW]) ?
          item_r.red - rd_data_r[4*CW-1:3*CW] : rd_data_r[4*CW-1:3*CW] - item_r.red;
    d_g = (item_r.green > rd_data_r[3*CW-1:2*CW]) ?
          item_r.green - rd_data_r[3*CW-1:2*CW] : rd_data_r[3*CW-1:2*CW] - item_r.green;
    d_b = (item_r.blue > rd_data_r[2*CW-1:CW]) ?
          item_r.blue - rd_data_r[2*CW-1:CW] : rd_data_r[2*CW-1:CW] - item_r.blue;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_idx_r <= issue_idx_r[IDX_W-1:0];
    end
    s2_idx_r   <= s1_idx_r;
    sq_r_r     <= SQ_W'(d_r) * SQ_W'(d_r);
    sq_g_r     <= SQ_W'(d_g) * SQ_W'(d_g);
    sq_b_r     <= SQ_W'(d_b) * SQ_W'(d_b);
    s2_match_r <= (rd_data_r == item_key);
  end

  // stage 2: sum of squares against the best so far
  assign dist_sum = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r    <= in_item;
      refused_r <= (in_item.mode == psnc_pkg::MODE_ADD) && full;
      // reserved entry holds all zeros, so a zero color is always found
      found_r   <= (in_item.mode == psnc_pkg::MODE_CONTAINS) && (in_key == '0);
      near_r    <= (in_item.mode == psnc_pkg::MODE_NEAREST) ? IDX_W'(1) : '0;
      best_r    <= '1;
    end else if (s2_vld_r) begin
      if ((item_r.mode == psnc_pkg::MODE_NEAREST) && (dist_sum < best_r)) begin
        best_r <= dist_sum;
        near_r <= s2_idx_r;
      end
      if ((item_r.mode == psnc_pkg::MODE_CONTAINS) && s2_match_r) begin
        found_r <= 1'b1;
      end
    end
  end

  // output register, frees the input side while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item_r.refused       <= refused_r;
      out_item_r.found         <= found_r;
      out_item_r.nearest_index <= 4'(near_r);
      out_item_r.entry_count   <= 5'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // palette count stays within one and the palette depth
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(1)) && (count_r <= CNT_W'(PALETTE_SIZE)))
    else $error("palette count out of range");

  // an accepted item always leaves idle on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != psnc_pkg::ST_IDLE))
    else $error("accepted item did not start");

  // the scan pipeline only carries data while a search runs
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r || s2_vld_r) |-> (state_r == psnc_pkg::ST_SCAN))
    else $error("scan pipeline busy outside search");

  // reads never run past the current count
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (issue_idx_r < count_r) && (issue_idx_r != CNT_W'(0)))
    else $error("read beyond palette");

  // a result is only loaded when the output register can take it
  assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

endmodule

/* bench/palette_store_nearest_color_test.sv */
// self-checking testbench for the palette store with exact-match and nearest-color search
module palette_store_nearest_color_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PALETTE_SIZE = psnc_pkg::PALETTE_SIZE_DEF;
  // the block ignores mode 3, but the field allows it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS     = 630;
  // random items in this window go out back to back
  localparam int unsigned BURST_FIRST      = 350;
  localparam int unsigned BURST_LAST       = 420;
  // receiver stops for a long stretch once this many items are in
  localparam int unsigned LONG_HOLD_AT     = 390;
  localparam int unsigned LONG_HOLD_CYCLES = 100;
  localparam int unsigned DRAIN_CYCLES     = 50;
  // longest correct silence: long hold + a search + a sender gap, taken many times over
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned PRINT_CAP        = 100;

  typedef struct {
    psnc_pkg::in_item_t item;
    int unsigned        gap;
    bit                 drain_first;
  } queued_request_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  psnc_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  psnc_pkg::out_item_t out_item;

  // items waiting to be offered, filled once at time zero
  queued_request_t queued_requests[$];
  // colors the stimulus expects the palette to hold, used to aim hits
  logic [31:0]     plan_color[$];

  // palette as predicted from accepted items
  logic [31:0]         model_entry [PALETTE_SIZE];
  int unsigned         model_count;
  psnc_pkg::out_item_t palette_replies_due[$];

  int unsigned sent_cnt = 0;
  int unsigned recv_cnt = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;

  palette_store_nearest_color #(
    .PALETTE_SIZE(PALETTE_SIZE)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // channel value with the extremes weighted up
  function automatic logic [7:0] pick_channel();
    logic [7:0] ch;
    case ($urandom_range(0, 7))
      0:       ch = 8'h00;
      1:       ch = 8'hff;
      default: ch = $urandom_range(0, 255);
    endcase
    return ch;
  endfunction

  // applies one accepted item to the predicted palette and records its reply
  function automatic void predict_palette_reply(psnc_pkg::in_item_t req);
    psnc_pkg::out_item_t reply;
    logic [31:0]         key;
    int unsigned         dist_sq, best;
    int                  dr, dg, db;
    reply = '0;
    best = 0;
    key = {req.red, req.green, req.blue, req.alpha};
    case (req.mode)
      psnc_pkg::MODE_ADD: begin
        if (model_count >= PALETTE_SIZE) begin
          reply.refused = 1'b1;
        end else begin
          model_entry[model_count] = key;
          model_count++;
        end
      end
      psnc_pkg::MODE_CONTAINS: begin
        // entry 0 takes part, so all-zero color always hits
        for (int i = 0; i < model_count; i++) begin
          if (model_entry[i] == key) reply.found = 1'b1;
        end
      end
      psnc_pkg::MODE_NEAREST: begin
        // only the reserved entry present: answer is 1
        reply.nearest_index = 4'd1;
        for (int i = 1; i < model_count; i++) begin
          dr = int'(req.red)   - int'(model_entry[i][31:24]);
          dg = int'(req.green) - int'(model_entry[i][23:16]);
          db = int'(req.blue)  - int'(model_entry[i][15:8]);
          dist_sq = dr * dr + dg * dg + db * db;
          // strict compare keeps the lower index on ties
          if (i == 1 || dist_sq < best) begin
            best = dist_sq;
            reply.nearest_index = 4'(i);
          end
        end
      end
      default: ;
    endcase
    reply.entry_count = 5'(model_count);
    palette_replies_due.push_back(reply);
  endfunction

  function automatic void queue_request(psnc_pkg::in_item_t req, int unsigned gap,
                                        bit drain_first);
    if (req.mode == psnc_pkg::MODE_ADD && plan_color.size() < PALETTE_SIZE) begin
      plan_color.push_back({req.red, req.green, req.blue, req.alpha});
    end
    queued_requests.push_back('{item: req, gap: gap, drain_first: drain_first});
  endfunction

  // random item aimed at stored colors most of the time
  function automatic psnc_pkg::in_item_t make_request();
    psnc_pkg::in_item_t req;
    logic [31:0]        base;
    int unsigned        pick;
    int unsigned        add_pct;
    base = plan_color[$urandom_range(0, plan_color.size() - 1)];
    pick = $urandom_range(0, 99);
    // adds are sparse while filling so every count sees many searches
    add_pct = (plan_color.size() < PALETTE_SIZE) ? 8 : 12;
    req = {MODE_UNUSED, pick_channel(), pick_channel(), pick_channel(), pick_channel()};
    if (pick < add_pct) begin
      req.mode = psnc_pkg::MODE_ADD;
      // repeated rgb with its own alpha makes nearest ties
      if ($urandom_range(0, 2) == 0) {req.red, req.green, req.blue} = base[31:8];
    end else if (pick < 55) begin
      req.mode = psnc_pkg::MODE_CONTAINS;
      case ($urandom_range(0, 9)) inside
        [0:4]: {req.red, req.green, req.blue, req.alpha} = base;
        [5:6]: begin
          // one bit off a stored color must miss unless another entry matches
          {req.red, req.green, req.blue, req.alpha} = base ^ (32'd1 << $urandom_range(0, 31));
        end
        default: ;
      endcase
    end else if (pick < 97) begin
      req.mode = psnc_pkg::MODE_NEAREST;
      case ($urandom_range(0, 5)) inside
        [0:1]: {req.red, req.green, req.blue} = base[31:8];
        [2:3]: begin
          {req.red, req.green, req.blue} = base[31:8] ^ (24'($urandom) & 24'h0f0f0f);
        end
        default: ;
      endcase
    end
    return req;
  endfunction

  // driver: offers queued items, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_palette_reply(in_item);
        sent_cnt <= sent_cnt + 1;
      end
      if (in_valid && !in_ready) begin
        // item still on offer, payload held
      end else if (queued_requests.size() == 0) begin
        in_valid <= 1'b0;
      end else if (queued_requests[0].gap != 0) begin
        in_valid <= 1'b0;
        queued_requests[0].gap = queued_requests[0].gap - 1;
      end else if (queued_requests[0].drain_first && (in_valid || sent_cnt != recv_cnt)) begin
        // pause until every outstanding reply is back
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_item  <= queued_requests[0].item;
        void'(queued_requests.pop_front());
      end
    end
  end

  // monitor: checks replies in order and throttles the receiver
  always @(posedge clk) begin
    psnc_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        recv_cnt <= recv_cnt + 1;
        if (palette_replies_due.size() == 0) begin
          report_mismatch($sformatf("reply %0d with none pending: %p", recv_cnt, out_item));
        end else begin
          want = palette_replies_due.pop_front();
          if (out_item.refused !== want.refused) begin
            report_mismatch($sformatf("reply %0d refused %b, predicted %b",
                                      recv_cnt, out_item.refused, want.refused));
          end
          if (out_item.found !== want.found) begin
            report_mismatch($sformatf("reply %0d found %b, predicted %b",
                                      recv_cnt, out_item.found, want.found));
          end
          if (out_item.nearest_index !== want.nearest_index) begin
            report_mismatch($sformatf("reply %0d nearest_index %0d, predicted %0d",
                                      recv_cnt, out_item.nearest_index, want.nearest_index));
          end
          if (out_item.entry_count !== want.entry_count) begin
            report_mismatch($sformatf("reply %0d entry_count %0d, predicted %0d",
                                      recv_cnt, out_item.entry_count, want.entry_count));
          end
        end
      end
      if (!long_hold_done && sent_cnt >= LONG_HOLD_AT) begin
        // long stall while the sender keeps going, so in_ready has to drop
        long_hold_done <= 1'b1;
        out_ready <= 1'b0;
        hold_left <= LONG_HOLD_CYCLES;
      end else if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if ((cycle_cnt / 400) % 4 == 1 || $urandom_range(0, 3) != 0) begin
        // one window in four never stalls
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold_left <= draw_gap();
      end
    end
  end

  // watchdog: counts cycles in which neither side moves an item
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("** palette_store_nearest_color: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 0; i < PALETTE_SIZE; i++) model_entry[i] = '0;
    model_count = 1;
    plan_color.push_back('0);

    // empty palette: nearest falls back to 1, zero color hits the reserved entry
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_NEAREST, 8'h80, 8'h80, 8'h80, 8'h80},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_CONTAINS, 8'h00, 8'h00, 8'h00, 8'h00},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_CONTAINS, 8'hff, 8'hff, 8'hff, 8'hff},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{MODE_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff},
                  draw_gap(), 1'b0);
    // first few entries: extremes, a zero duplicate, same rgb with another alpha
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_ADD, 8'hff, 8'hff, 8'hff, 8'hff},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_ADD, 8'h00, 8'h00, 8'h00, 8'h00},
                  draw_gap(), 1'b1);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_ADD, 8'hff, 8'h00, 8'h80, 8'h01},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_ADD, 8'hff, 8'hff, 8'hff, 8'h00},
                  draw_gap(), 1'b0);
    // white ties between entries 1 and 4, lower one wins
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_NEAREST, 8'hff, 8'hff, 8'hff, 8'h5a},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_CONTAINS, 8'hff, 8'hff, 8'hff, 8'h00},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_CONTAINS, 8'hff, 8'hff, 8'hff, 8'h80},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_NEAREST, 8'h00, 8'h00, 8'h00, 8'hff},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_NEAREST, 8'hc8, 8'h0a, 8'h64, 8'h00},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_NEAREST, 8'h80, 8'h80, 8'h80, 8'h80},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{MODE_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_ADD, 8'h00, 8'hff, 8'h00, 8'haa},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_ADD, 8'h55, 8'haa, 8'hff, 8'h55},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_CONTAINS, 8'h00, 8'hff, 8'h00, 8'haa},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_CONTAINS, 8'h55, 8'haa, 8'hff, 8'hd5},
                  draw_gap(), 1'b0);
    queue_request(psnc_pkg::in_item_t'{psnc_pkg::MODE_NEAREST, 8'h00, 8'hff, 8'hff, 8'h00},
                  draw_gap(), 1'b0);

    // random part: palette fills slowly, then stays full with adds refused
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      queue_request(make_request(),
                    (k >= BURST_FIRST && k < BURST_LAST) ? 0 : draw_gap(),
                    k == 200 || k == 450);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_requests.size() != 0 || in_valid) @(posedge clk);
    while (recv_cnt != sent_cnt) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (palette_replies_due.size() != 0) begin
      report_mismatch($sformatf("%0d replies never arrived", palette_replies_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("** palette_store_nearest_color: PASSED **");
    end else begin
      $display("** palette_store_nearest_color: FAILED **");
    end
    $finish;
  end

endmodule
